// ===== src/awt_pkg.sv =====
// Shared types and constants for the alphanumeric word tokenizer.
package awt_pkg;

   // Default buffer size in bytes, and the width of a job's word length field.
   localparam int BUFFER_BYTES_DEF = 64;
   localparam int JOB_LEN_W        = 7;
   localparam int CSR_W            = 7;
   localparam int CMP_W            = 8;
   localparam logic [CSR_W-1:0] MAX_LEN_RESET = 7'd32;

   // Output queue depth and the width of its fill count.
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_PTR_W = 2;
   localparam int OUTQ_CNT_W = 3;

   // ASCII codes used by the classifier.
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // One input request: a text byte or an end-of-line marker.
   typedef struct packed {
      logic [7:0] char_in;
      logic       line_end;
   } req_type;

   // One result: a byte of a kept word.
   typedef struct packed {
      logic [7:0] word_char;
      logic       word_last;
   } rsp_type;

   // A finished word handed from the front to the back.
   typedef struct packed {
      logic                 valid;
      logic                 bank;
      logic [JOB_LEN_W-1:0] len;
   } job_type;

   // Byte write into the word buffer (index travels separately).
   typedef struct packed {
      logic       en;
      logic       bank;
      logic [7:0] data;
   } buf_wr_type;

   // The back has issued the last read of a bank.
   typedef struct packed {
      logic valid;
      logic bank;
   } done_type;

   // Lower-case an ASCII byte.
   function automatic logic [7:0] lower_ascii(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

// ===== src/awt_front.sv =====
// Front end: classifies requests, builds the current word and hands finished words on.
module awt_front #(
   parameter int BUFFER_BYTES = awt_pkg::BUFFER_BYTES_DEF,
   parameter int IDX_W        = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1,
   parameter int CNT_W        = $clog2(BUFFER_BYTES + 2)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  awt_pkg::req_type            req_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [awt_pkg::CSR_W-1:0]   csr_wdata,
   input  logic                        job_ready,
   output awt_pkg::job_type            job_o,
   output awt_pkg::buf_wr_type         wr_o,
   output logic [IDX_W-1:0]            wr_idx,
   input  awt_pkg::done_type           done_i
);

   logic [awt_pkg::CSR_W-1:0] max_len_ff, max_len_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      in_word_ff, in_word_in;
   logic                      has_letter_ff, has_letter_in;
   logic                      cur_bank_ff, cur_bank_in;
   logic [1:0]                busy_ff, busy_in;

   logic                      accept;
   logic [7:0]                ch;
   logic                      is_letter, is_digit, is_alnum;
   logic [awt_pkg::CMP_W-1:0] limit;
   logic                      keep;

   // Configuration register is always writable.
   assign csr_ready = 1'b1;

   // Stall while the bank being filled still waits to be read out, or while the job queue is full.
   assign full   = busy_ff[cur_bank_ff] || !job_ready;
   assign accept = push && !full;

   // Classify the lower-cased byte.
   always_comb begin
      ch        = awt_pkg::lower_ascii(req_data.char_in);
      is_letter = (ch >= awt_pkg::CH_LOWER_A) && (ch <= awt_pkg::CH_LOWER_Z);
      is_digit  = (ch >= awt_pkg::CH_DIGIT_0) && (ch <= awt_pkg::CH_DIGIT_9);
      is_alnum  = !req_data.line_end && (is_letter || is_digit);
   end

   // Effective limit is the smaller of the register and the buffer size.
   always_comb begin
      if (awt_pkg::CMP_W'(max_len_ff) > awt_pkg::CMP_W'(BUFFER_BYTES)) begin
         limit = awt_pkg::CMP_W'(BUFFER_BYTES);
      end else begin
         limit = awt_pkg::CMP_W'(max_len_ff);
      end
      keep = in_word_ff && has_letter_ff && (awt_pkg::CMP_W'(count_ff) <= limit);
   end

   // Buffer write of the current byte while the word still fits.
   always_comb begin
      wr_o.en   = accept && is_alnum && (count_ff < CNT_W'(BUFFER_BYTES));
      wr_o.bank = cur_bank_ff;
      wr_o.data = ch;
      wr_idx    = count_ff[IDX_W-1:0];
   end

   // Word bookkeeping and job handoff.
   always_comb begin
      max_len_in    = max_len_ff;
      count_in      = count_ff;
      in_word_in    = in_word_ff;
      has_letter_in = has_letter_ff;
      cur_bank_in   = cur_bank_ff;
      busy_in       = busy_ff;
      job_o.valid   = 1'b0;
      job_o.bank    = cur_bank_ff;
      job_o.len     = awt_pkg::JOB_LEN_W'(count_ff);

      if (csr_valid) begin
         max_len_in = csr_wdata;
      end

      if (done_i.valid) begin
         busy_in[done_i.bank] = 1'b0;
      end

      if (accept) begin
         if (is_alnum) begin
            in_word_in    = 1'b1;
            has_letter_in = has_letter_ff || is_letter;
            if (count_ff <= CNT_W'(BUFFER_BYTES)) begin
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            if (keep) begin
               job_o.valid          = 1'b1;
               busy_in[cur_bank_ff] = 1'b1;
               cur_bank_in          = !cur_bank_ff;
            end
            in_word_in    = 1'b0;
            has_letter_in = 1'b0;
            count_in      = '0;
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff    <= awt_pkg::MAX_LEN_RESET;
         count_ff      <= '0;
         in_word_ff    <= 1'b0;
         has_letter_ff <= 1'b0;
         cur_bank_ff   <= 1'b0;
         busy_ff       <= '0;
      end else begin
         max_len_ff    <= max_len_in;
         count_ff      <= count_in;
         in_word_ff    <= in_word_in;
         has_letter_ff <= has_letter_in;
         cur_bank_ff   <= cur_bank_in;
         busy_ff       <= busy_in;
      end
   end

endmodule

// ===== src/awt_jobq.sv =====
// Two-entry queue of finished words between the front and the back.
module awt_jobq (
   input  logic             clock,
   input  logic             reset,
   input  awt_pkg::job_type push_job,
   output logic             ready,
   output awt_pkg::job_type head_job,
   input  logic             pop
);

   awt_pkg::job_type slot_ff [2];
   awt_pkg::job_type slot_in [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign ready   = (cnt_ff != 2'd2);
   assign do_push = push_job.valid && ready;
   assign do_pop  = pop && (cnt_ff != 2'd0);

   // Head entry, marked valid only when something is queued.
   always_comb begin
      head_job       = slot_ff[rd_ptr_ff];
      head_job.valid = (cnt_ff != 2'd0);
   end

   // Pointer and count update.
   always_comb begin
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         slot_in[wr_ptr_ff] = push_job;
         wr_ptr_in          = !wr_ptr_ff;
      end
      if (do_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== src/awt_back.sv =====
// Back end: word buffer memory, read-out sequencer and result queue.
module awt_back #(
   parameter int BUFFER_BYTES = awt_pkg::BUFFER_BYTES_DEF,
   parameter int IDX_W        = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  awt_pkg::buf_wr_type wr_i,
   input  logic [IDX_W-1:0]    wr_idx,
   input  awt_pkg::job_type    job_i,
   output logic                job_pop,
   output awt_pkg::done_type   done_o,
   output logic                empty,
   input  logic                pop,
   output awt_pkg::rsp_type    rsp_data
);

   // Two banks: one being filled by the front, one being read here.
   logic [7:0] mem [2][BUFFER_BYTES];

   logic [IDX_W-1:0]               rd_idx_ff, rd_idx_in;
   logic                           rdv_ff;
   logic                           rd_last_ff;
   logic [7:0]                     rd_data_ff;

   awt_pkg::rsp_type               outq_ff [awt_pkg::OUTQ_DEPTH];
   logic [awt_pkg::OUTQ_PTR_W-1:0] head_ff, head_in;
   logic [awt_pkg::OUTQ_PTR_W-1:0] tail_ff, tail_in;
   logic [awt_pkg::OUTQ_CNT_W-1:0] cnt_ff, cnt_in;

   logic                           space;
   logic                           issue;
   logic                           issue_last;
   logic                           do_pop;

   // Room for one more byte, counting the read in flight.
   assign space = (cnt_ff + awt_pkg::OUTQ_CNT_W'(rdv_ff)) <
                  awt_pkg::OUTQ_CNT_W'(awt_pkg::OUTQ_DEPTH);
   assign issue = job_i.valid && space;
   assign issue_last = (awt_pkg::JOB_LEN_W'(rd_idx_ff) + awt_pkg::JOB_LEN_W'(1)) == job_i.len;

   assign job_pop      = issue && issue_last;
   assign done_o.valid = issue && issue_last;
   assign done_o.bank  = job_i.bank;

   // Read index steps through the word and restarts for the next one.
   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (issue) begin
         if (issue_last) begin
            rd_idx_in = '0;
         end else begin
            rd_idx_in = rd_idx_ff + IDX_W'(1);
         end
      end
   end

   // Buffer write port.
   always_ff @(posedge clock) begin
      if (wr_i.en) begin
         mem[wr_i.bank][wr_idx] <= wr_i.data;
      end
   end

   // Buffer read port with registered data.
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= mem[job_i.bank][rd_idx_ff];
         rd_last_ff <= issue_last;
      end
   end

   // Result queue control.
   assign empty    = (cnt_ff == '0);
   assign do_pop   = pop && !empty;
   assign rsp_data = outq_ff[head_ff];

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      if (rdv_ff) begin
         tail_in = tail_ff + awt_pkg::OUTQ_PTR_W'(1);
      end
      if (do_pop) begin
         head_in = head_ff + awt_pkg::OUTQ_PTR_W'(1);
      end
      if (rdv_ff && !do_pop) begin
         cnt_in = cnt_ff + awt_pkg::OUTQ_CNT_W'(1);
      end else if (!rdv_ff && do_pop) begin
         cnt_in = cnt_ff - awt_pkg::OUTQ_CNT_W'(1);
      end
   end

   // Result queue storage.
   always_ff @(posedge clock) begin
      if (rdv_ff) begin
         outq_ff[tail_ff] <= '{word_char: rd_data_ff, word_last: rd_last_ff};
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff <= '0;
         rdv_ff    <= 1'b0;
         head_ff   <= '0;
         tail_ff   <= '0;
         cnt_ff    <= '0;
      end else begin
         rd_idx_ff <= rd_idx_in;
         rdv_ff    <= issue;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== src/alnum_word_tokenizer_unit.sv =====
// Top level of the alphanumeric word tokenizer: front, job queue and back.
//
//   channel   handshake            payload
//   request   push / full          req_data  (char_in, line_end)
//   result    pop / empty          rsp_data  (word_char, word_last)
//   config    csr_valid/csr_ready  csr_wdata (max_word_length)
//
// Each request is accepted while full is low. A kept word's first byte passes the job queue,
// read register and result queue; the rest follow one per cycle unless the result queue fills.
// The front fills one of two buffer banks while the back reads the other; full
// rises when the bank to fill is still being read out.
// Reset is synchronous and clears all control state; buffer contents are not reset.
// A stalled result side fills the four-entry result queue and then holds the back.
module alnum_word_tokenizer_unit #(
   parameter int BUFFER_BYTES = awt_pkg::BUFFER_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  awt_pkg::req_type          req_data,
   output logic                      empty,
   input  logic                      pop,
   output awt_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [awt_pkg::CSR_W-1:0] csr_wdata
);

   localparam int IDX_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
   localparam int CNT_W = $clog2(BUFFER_BYTES + 2);

   awt_pkg::job_type    job_push;
   awt_pkg::job_type    job_head;
   logic                job_ready;
   logic                job_pop;
   awt_pkg::buf_wr_type buf_wr;
   logic [IDX_W-1:0]    buf_wr_idx;
   awt_pkg::done_type   done;

   // Request side: classify and collect words.
   awt_front #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .IDX_W        (IDX_W),
      .CNT_W        (CNT_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .job_ready (job_ready),
      .job_o     (job_push),
      .wr_o      (buf_wr),
      .wr_idx    (buf_wr_idx),
      .done_i    (done)
   );

   // Finished words waiting for read-out.
   awt_jobq u_jobq (
      .clock    (clock),
      .reset    (reset),
      .push_job (job_push),
      .ready    (job_ready),
      .head_job (job_head),
      .pop      (job_pop)
   );

   // Result side: read words out byte by byte.
   awt_back #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .IDX_W        (IDX_W)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .wr_i     (buf_wr),
      .wr_idx   (buf_wr_idx),
      .job_i    (job_head),
      .job_pop  (job_pop),
      .done_o   (done),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   // A finished word is never offered to a full job queue.
   assert property (@(posedge clock) disable iff (reset)
      job_push.valid |-> job_ready)
      else $error("word handed over while job queue full");

   // The back only finishes a bank for a queued word.
   assert property (@(posedge clock) disable iff (reset)
      done.valid |-> job_head.valid)
      else $error("bank released with no word queued");

   // The front never writes the bank the back is releasing.
   assert property (@(posedge clock) disable iff (reset)
      (buf_wr.en && done.valid) |-> (buf_wr.bank != done.bank))
      else $error("buffer write into a bank still being read");

endmodule
